### rtl/core/wmm_pkg.sv
package wmm_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_WINDOW   = 16;
    localparam int PIXEL_BITS   = 16;
    localparam int HEIGHT_LIMIT = 1024;

    localparam int CFG_BITS  = 11;
    localparam int WS_BITS   = 5;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(HEIGHT_LIMIT);
    localparam int LINE_BITS = $clog2(MAX_WINDOW);
    localparam int TAP_BITS  = $clog2(MAX_WINDOW);
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_BITS = LINE_BITS + COL_BITS;
    localparam int WORD_BITS = 2 * PIXEL_BITS;

    localparam int IDX_BITS = 2;
    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_WINDOW_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HSCAN,
        S_HWRITE,
        S_VSCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                shift;
        logic [TAP_BITS-1:0] sel;
    } tap_ctl_t;

endpackage

### rtl/core/window_min_max_range_2d.sv
// Sliding n-by-n minimum/maximum over a raster-order frame (n = window_size).
// When a row window completes, the row maxima and minima are scanned one tap
// per cycle and written to the line buffer; when a square window completes,
// the line buffer, one memory with a single read port, is then read one row
// per cycle. The emit step also waits for as long as the previous result
// word is still held by out_stall.
// in_stall is high while a pixel is in work. Line buffers need no clearing,
// so no wait after reset.
// Configuration may be written only while idle; cfg_ready is always high.
module window_min_max_range_2d
    import wmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_BITS-1:0] pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIXEL_BITS-1:0] window_max,
    output logic [PIXEL_BITS-1:0] window_min,
    output logic [PIXEL_BITS-1:0] best_range,
    output logic                  window_found,
    output logic                  frame_last
);

    localparam logic [PIXEL_BITS-1:0] PIX_ONES = '1;

    logic [CFG_BITS-1:0] fw_reg, fh_reg;
    logic [WS_BITS-1:0]  ws_reg;

    state_t state_reg, state_next;

    logic [COL_BITS-1:0]   col_reg, col_next, colc_reg, colc_next;
    logic [ROW_BITS-1:0]   row_reg, row_next, rowc_reg, rowc_next;
    logic                  lastc_reg, lastc_next, last_reg, last_next;
    logic                  winh_reg, winh_next, winv_reg, winv_next;
    logic [TAP_BITS-1:0]   hk_reg, hk_next;
    logic [CNT_BITS-1:0]   vk_reg, vk_next;
    logic                  rdv_reg, rdv_next;
    logic [PIXEL_BITS-1:0] hmax_reg, hmax_next, hmin_reg, hmin_next;
    logic [PIXEL_BITS-1:0] vmax_reg, vmax_next, vmin_reg, vmin_next;
    logic [PIXEL_BITS-1:0] best_reg, best_next;
    logic                  seen_reg, seen_next;

    logic                  ov_reg, ov_next;
    logic [PIXEL_BITS-1:0] omax_reg, omax_next, omin_reg, omin_next, obest_reg, obest_next;
    logic                  ofound_reg, ofound_next, olast_reg, olast_next;

    logic [CFG_BITS-1:0]   w_cl, h_cl;
    logic [WS_BITS-1:0]    n_cl;
    logic [CFG_BITS-1:0]   col_clamp, row_clamp;
    logic                  in_acc;
    logic [PIXEL_BITS-1:0] tap, rd_max, rd_min, range_v;
    logic [WORD_BITS-1:0]  rdata;
    mem_req_t              req;
    tap_ctl_t              tctl;

    always_comb
    begin
        w_cl = (fw_reg == '0) ? CFG_BITS'(1)
             : ((fw_reg > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH) : fw_reg);
        h_cl = (fh_reg == '0) ? CFG_BITS'(1)
             : ((fh_reg > CFG_BITS'(HEIGHT_LIMIT)) ? CFG_BITS'(HEIGHT_LIMIT) : fh_reg);
        n_cl = (ws_reg == '0) ? WS_BITS'(1)
             : ((ws_reg > WS_BITS'(MAX_WINDOW)) ? WS_BITS'(MAX_WINDOW) : ws_reg);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= CFG_BITS'(1024);
            fh_reg <= CFG_BITS'(1024);
            ws_reg <= WS_BITS'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                REG_WINDOW_SIZE:  ws_reg <= cfg_data[WS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign tctl.shift = in_acc;
    assign tctl.sel   = hk_reg;

    wmm_row_shift u_row_shift
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tctl),
        .din   (pixel),
        .tap   (tap)
    );

    wmm_line_mem u_line_mem
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign rd_max  = rdata[WORD_BITS-1:PIXEL_BITS];
    assign rd_min  = rdata[PIXEL_BITS-1:0];
    assign range_v = (vmax_reg >= vmin_reg) ? (vmax_reg - vmin_reg) : '0;

    always_comb
    begin
        col_clamp   = ({1'b0, col_reg} >= w_cl) ? (w_cl - CFG_BITS'(1)) : {1'b0, col_reg};
        row_clamp   = ({1'b0, row_reg} >= h_cl) ? (h_cl - CFG_BITS'(1)) : {1'b0, row_reg};
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        colc_next   = colc_reg;
        rowc_next   = rowc_reg;
        lastc_next  = lastc_reg;
        last_next   = last_reg;
        winh_next   = winh_reg;
        winv_next   = winv_reg;
        hk_next     = hk_reg;
        vk_next     = vk_reg;
        rdv_next    = 1'b0;
        hmax_next   = hmax_reg;
        hmin_next   = hmin_reg;
        vmax_next   = vmax_reg;
        vmin_next   = vmin_reg;
        best_next   = best_reg;
        seen_next   = seen_reg;
        ov_next     = ov_reg && out_stall;
        omax_next   = omax_reg;
        omin_next   = omin_reg;
        obest_next  = obest_reg;
        ofound_next = ofound_reg;
        olast_next  = olast_reg;
        req.we      = 1'b0;
        req.waddr   = {rowc_reg[LINE_BITS-1:0], colc_reg};
        req.wdata   = {hmax_reg, hmin_reg};
        req.re      = 1'b0;
        req.raddr   = {rowc_reg[LINE_BITS-1:0] - vk_reg[LINE_BITS-1:0], colc_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    lastc_next = ({1'b0, col_reg} + CFG_BITS'(1)) >= w_cl;
                    last_next  = lastc_next && (({1'b0, row_reg} + CFG_BITS'(1)) >= h_cl);
                    colc_next  = col_clamp[COL_BITS-1:0];
                    rowc_next  = row_clamp[ROW_BITS-1:0];
                    winh_next  = (col_clamp + CFG_BITS'(1)) >= CFG_BITS'(n_cl);
                    winv_next  = (row_clamp + CFG_BITS'(1)) >= CFG_BITS'(n_cl);
                    hk_next    = '0;
                    hmax_next  = '0;
                    hmin_next  = PIX_ONES;
                    state_next = winh_next ? S_HSCAN : S_EMIT;
                end
            end
            S_HSCAN:
            begin
                if (tap > hmax_reg) hmax_next = tap;
                if (tap < hmin_reg) hmin_next = tap;
                hk_next = hk_reg + TAP_BITS'(1);
                if (CNT_BITS'(hk_reg) + CNT_BITS'(1) >= CNT_BITS'(n_cl))
                begin
                    state_next = S_HWRITE;
                end
            end
            S_HWRITE:
            begin
                req.we     = 1'b1;
                vk_next    = '0;
                vmax_next  = '0;
                vmin_next  = PIX_ONES;
                state_next = winv_reg ? S_VSCAN : S_EMIT;
            end
            S_VSCAN:
            begin
                if (vk_reg < CNT_BITS'(n_cl))
                begin
                    req.re   = 1'b1;
                    rdv_next = 1'b1;
                    vk_next  = vk_reg + CNT_BITS'(1);
                end
                if (rdv_reg)
                begin
                    if (rd_max > vmax_reg) vmax_next = rd_max;
                    if (rd_min < vmin_reg) vmin_next = rd_min;
                end
                else if (vk_reg >= CNT_BITS'(n_cl))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!(ov_reg && out_stall))
                begin
                    if (winh_reg && winv_reg)
                    begin
                        ov_next     = 1'b1;
                        omax_next   = vmax_reg;
                        omin_next   = vmin_reg;
                        obest_next  = (range_v < best_reg) ? range_v : best_reg;
                        ofound_next = 1'b1;
                        olast_next  = last_reg;
                        best_next   = obest_next;
                        seen_next   = 1'b1;
                    end
                    else if (last_reg)
                    begin
                        ov_next     = 1'b1;
                        omax_next   = '0;
                        omin_next   = '0;
                        obest_next  = best_reg;
                        ofound_next = seen_reg;
                        olast_next  = 1'b1;
                    end
                    if (last_reg)
                    begin
                        col_next  = '0;
                        row_next  = '0;
                        best_next = PIX_ONES;
                        seen_next = 1'b0;
                    end
                    else if (lastc_reg)
                    begin
                        col_next = '0;
                        row_next = rowc_reg + ROW_BITS'(1);
                    end
                    else
                    begin
                        col_next = colc_reg + COL_BITS'(1);
                        row_next = rowc_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            best_reg  <= PIX_ONES;
            seen_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            best_reg  <= best_next;
            seen_reg  <= seen_next;
            ov_reg    <= ov_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colc_reg   <= colc_next;
        rowc_reg   <= rowc_next;
        lastc_reg  <= lastc_next;
        last_reg   <= last_next;
        winh_reg   <= winh_next;
        winv_reg   <= winv_next;
        hk_reg     <= hk_next;
        vk_reg     <= vk_next;
        hmax_reg   <= hmax_next;
        hmin_reg   <= hmin_next;
        vmax_reg   <= vmax_next;
        vmin_reg   <= vmin_next;
        omax_reg   <= omax_next;
        omin_reg   <= omin_next;
        obest_reg  <= obest_next;
        ofound_reg <= ofound_next;
        olast_reg  <= olast_next;
    end

    assign out_valid    = ov_reg;
    assign window_max   = omax_reg;
    assign window_min   = omin_reg;
    assign best_range   = obest_reg;
    assign window_found = ofound_reg;
    assign frame_last   = olast_reg;

endmodule

### rtl/core/wmm_line_mem.sv
module wmm_line_mem
    import wmm_pkg::*;
(
    input  logic                 clk,
    input  mem_req_t             req,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [0:(1 << ADDR_BITS) - 1];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/wmm_row_shift.sv
module wmm_row_shift
    import wmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tap_ctl_t              ctl,
    input  logic [PIXEL_BITS-1:0] din,
    output logic [PIXEL_BITS-1:0] tap
);

    logic [PIXEL_BITS-1:0] taps_reg [0:MAX_WINDOW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else if (ctl.shift)
        begin
            for (int i = MAX_WINDOW - 1; i > 0; i--)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
            taps_reg[0] <= din;
        end
    end

    assign tap = taps_reg[ctl.sel];

endmodule

### rtl/core/wmm_checker.sv
module wmm_checker
    import wmm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_ready,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [PIXEL_BITS-1:0] window_max,
    input logic [PIXEL_BITS-1:0] window_min,
    input logic [PIXEL_BITS-1:0] best_range,
    input logic                  window_found
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_max) && $stable(best_range))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pixel taken while one is in work");

    a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_found |-> window_max >= window_min)
        else $error("window max below window min");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_found |-> best_range <= window_max - window_min)
        else $error("best range above current window range");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind window_min_max_range_2d wmm_checker u_wmm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_max   (window_max),
    .window_min   (window_min),
    .best_range   (best_range),
    .window_found (window_found)
);

### tb/window_min_max_range_2d_tb.sv
module window_min_max_range_2d_tb;
    import wmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 2 * MAX_WINDOW + 10;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] wmax;
        logic [PIXEL_BITS-1:0] wmin;
        logic [PIXEL_BITS-1:0] best;
        logic                  found;
        logic                  last;
    } window_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [CFG_BITS-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  out_valid;
    logic                  out_stall;
    logic [PIXEL_BITS-1:0] window_max;
    logic [PIXEL_BITS-1:0] window_min;
    logic [PIXEL_BITS-1:0] best_range;
    logic                  window_found;
    logic                  frame_last;

    window_min_max_range_2d uut (.*);

    logic [PIXEL_BITS-1:0] pixel_q[$];
    window_word_t          window_q[$];
    int                    mismatches;
    int                    cycles;
    int                    in_gap;
    int                    out_gap;
    int                    queued;
    bit                    idle_on;

    // predictor copy of the block
    logic [CFG_BITS-1:0]   shadow_width;
    logic [CFG_BITS-1:0]   shadow_height;
    logic [WS_BITS-1:0]    shadow_win;
    logic [PIXEL_BITS-1:0] taps[MAX_WINDOW];
    logic [PIXEL_BITS-1:0] line_max[MAX_WINDOW][MAX_WIDTH];
    logic [PIXEL_BITS-1:0] line_min[MAX_WINDOW][MAX_WIDTH];
    int                    cur_row;
    int                    cur_col;
    logic [PIXEL_BITS-1:0] min_range;
    bit                    seen_window;

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void predict_window(logic [PIXEL_BITS-1:0] px);
        int w, h, n, col, row, k, l;
        bit last_col, last, got;
        logic [PIXEL_BITS-1:0] hmax, hmin, vmax, vmin, rng;
        window_word_t r;
        w = clamp(shadow_width, 1, MAX_WIDTH);
        h = clamp(shadow_height, 1, HEIGHT_LIMIT);
        n = clamp(shadow_win, 1, MAX_WINDOW);
        col = cur_col;
        row = cur_row;
        last_col = col + 1 >= w;
        last = last_col && row + 1 >= h;
        got = 0;
        if (col >= w) col = w - 1;
        if (row >= h) row = h - 1;
        for (k = MAX_WINDOW - 1; k > 0; k--) taps[k] = taps[k-1];
        taps[0] = px;
        if (col + 1 >= n) begin
            hmax = '0;
            hmin = '1;
            for (k = 0; k < n; k++) begin
                if (taps[k] > hmax) hmax = taps[k];
                if (taps[k] < hmin) hmin = taps[k];
            end
            line_max[row % MAX_WINDOW][col] = hmax;
            line_min[row % MAX_WINDOW][col] = hmin;
            if (row + 1 >= n) begin
                vmax = '0;
                vmin = '1;
                for (k = 0; k < n; k++) begin
                    l = (row + MAX_WINDOW - k) % MAX_WINDOW;
                    if (line_max[l][col] > vmax) vmax = line_max[l][col];
                    if (line_min[l][col] < vmin) vmin = line_min[l][col];
                end
                rng = vmax >= vmin ? vmax - vmin : '0;
                if (rng < min_range) min_range = rng;
                seen_window = 1;
                r = '{vmax, vmin, min_range, 1'b1, last};
                window_q.insert(window_q.size(), r);
                got = 1;
            end
        end
        if (last && !got) begin
            r = '{'0, '0, min_range, seen_window, 1'b1};
            window_q.insert(window_q.size(), r);
        end
        if (last) begin
            cur_row = 0;
            cur_col = 0;
            min_range = '1;
            seen_window = 0;
        end else if (last_col) begin
            cur_col = 0;
            cur_row = row + 1;
        end else begin
            cur_col = col + 1;
            cur_row = row;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    function automatic void queue_pixel(logic [PIXEL_BITS-1:0] v);
        pixel_q.insert(pixel_q.size(), v);
        queued++;
    endfunction

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            pixel <= '0;
            in_gap <= 0;
        end else begin
            if (in_valid && !in_stall) predict_window(pixel);
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 0;
                end else if (pixel_q.size() > 0) begin
                    in_valid <= 1;
                    pixel <= pixel_q[0];
                    pixel_q.delete(0);
                    in_gap <= pick_gap();
                end else begin
                    in_valid <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_width <= CFG_BITS'(1024);
            shadow_height <= CFG_BITS'(1024);
            shadow_win <= WS_BITS'(2);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  shadow_width <= cfg_data;
                REG_FRAME_HEIGHT: shadow_height <= cfg_data;
                REG_WINDOW_SIZE:  shadow_win <= cfg_data[WS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        window_word_t got, want;
        if (!rst_n) begin
            out_stall <= 0;
            out_gap <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{window_max, window_min, best_range, window_found, frame_last};
                if (window_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", got);
                end else begin
                    want = window_q[0];
                    window_q.delete(0);
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("expected %p got %p", want, got);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1;
            end else begin
                out_gap <= pick_gap();
                out_stall <= 0;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_BITS-1:0] idx, int v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_BITS'(v);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(int w, int h, int n);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_WINDOW_SIZE, n);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pixel_q.size() > 0 || in_valid || window_q.size() > 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_pixels(int count, int style);
        int i;
        logic [PIXEL_BITS-1:0] base;
        base = PIXEL_BITS'($urandom);
        for (i = 0; i < count; i++) begin
            case (style)
                0: queue_pixel(PIXEL_BITS'($urandom));
                1: queue_pixel(base + PIXEL_BITS'($urandom_range(7)));
                2: queue_pixel($urandom_range(1) ? '1 : '0);
                default: queue_pixel(base);
            endcase
        end
    endtask

    initial begin
        int w, h, n, we, he, frames;
        mismatches = 0;
        cycles = 0;
        queued = 0;
        idle_on = 1;
        cur_row = 0;
        cur_col = 0;
        min_range = '1;
        seen_window = 0;
        foreach (taps[k]) taps[k] = '0;
        cfg_valid = 0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        configure(3, 3, 2);
        queue_pixel('0);
        queue_pixel('1);
        push_pixels(7, 2);
        drain();
        configure(0, 0, 0);
        push_pixels(2, 0);
        drain();
        configure(2, 2, 31);
        push_pixels(4, 0);
        drain();
        configure(4, 8, 2);
        push_pixels(20, 0);
        drain();
        write_reg(REG_FRAME_HEIGHT, 3);
        cfg_valid <= 0;
        push_pixels(4, 0);
        drain();
        configure(2047, 1, 1);
        push_pixels(1024, 1);
        drain();

        while (queued < 1850) begin
            idle_on = $urandom_range(3) != 0;
            w = $urandom_range(24, 1);
            h = $urandom_range(12, 1);
            n = $urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(6, 1);
            configure(w, h, n);
            we = clamp(w, 1, MAX_WIDTH);
            he = clamp(h, 1, HEIGHT_LIMIT);
            frames = $urandom_range(2, 1);
            push_pixels(we * he * frames, $urandom_range(3));
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
